// ----- sv/sha256_sha224_hash_core_assert.svh -----
// assertion macros for the hash core
`ifndef SHA256_SHA224_HASH_CORE_ASSERT_SVH
`define SHA256_SHA224_HASH_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- sv/shah_pkg.sv -----
package shah_pkg;
  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_ROUND, ST_ADD, ST_OUT
  } state_t;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic word_t init_hash(input logic m, input logic [2:0] i);
    word_t h256 [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    word_t h224 [8] = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
                        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
    return m ? h224[i] : h256[i];
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

// ----- sv/shah_round.sv -----
// one compression round plus the message schedule shift line
module shah_round (
  input  logic clk,
  input  logic load,
  input  logic step,
  input  shah_pkg::word_t blk [16],
  input  shah_pkg::word_t hin [8],
  input  logic [5:0] rnd,
  output shah_pkg::word_t v [8]
);
  import shah_pkg::*;
  word_t w [16];
  word_t s0, s1, wnew, t1, t2, e, a;

  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wnew = w[0] + s0 + w[9] + s1;
    e = v[4];
    a = v[0];
    t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
         + round_k(rnd) + w[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      w <= blk;
      v <= hin;
    end else if (step) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= wnew;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= e; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= a; v[0] <= t1 + t2;
    end
  end
endmodule

// ----- sv/sha256_sha224_hash_core.sv -----
// Hashes a byte message with SHA-256 (mode 0) or SHA-224 (mode 1). A non-last word
// is stored in the block; one that fills a 16-word block starts a compression by the
// single round unit, running 64 rounds at one per cycle plus load and add. A last
// word pads one word per cycle, runs one or two compressions, then delivers 8 (or 7)
// digest beats. Input stall is high while a mode write is offered and whenever the
// core is not idle: padding, compressing or delivering the digest.
module sha256_sha224_hash_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0] byte_count,
  input  logic last_word,
  output logic out_valid,
  input  logic out_stall,
  output logic [31:0] digest_word,
  output logic [2:0] word_index,
  output logic last_digest_word
);
  import shah_pkg::*;
`include "sha256_sha224_hash_core_assert.svh"

  state_t state, state_next;
  logic mode;
  word_t hv [8];
  word_t blk [16];
  word_t blk_in [16];
  word_t v [8];
  logic [63:0] bit_count;
  logic [3:0] wpos;
  logic [5:0] rnd;
  logic [2:0] oidx;
  logic [1:0] pad_phase; // 0 zeros, 1 high count, 2 low count, 3 done
  logic [1:0] ph;
  logic in_msg, load, step, push, last_blk, need80;
  word_t push_data, lw;
  logic [2:0] cnt;
  logic [31:0] keep;

  shah_round u_round (.clk, .load, .step, .blk(blk_in), .hin(hv), .rnd, .v);

  assign cfg_ready = (state == ST_IDLE);
  assign in_stall = (state != ST_IDLE) || cfg_valid;
  assign out_valid = (state == ST_OUT);
  assign digest_word = hv[oidx];
  assign word_index = oidx;
  assign last_digest_word = (oidx == (mode ? 3'd6 : 3'd7));
  assign cnt = (byte_count > 3'd4) ? 3'd4 : byte_count;
  assign keep = (cnt == 3'd0) ? 32'h0 : (32'hffffffff << (6'd8 * (6'd4 - {3'd0, cnt})));
  assign lw = (data_word & keep) | (32'h80 << (6'd8 * (6'd3 - {3'd0, cnt})));
  assign in_msg = in_valid && !in_stall;
  // padding that starts at word 14 goes straight to the length
  assign ph = (pad_phase == 2'd0 && !need80 && wpos == 4'd14) ? 2'd1 : pad_phase;

  always_comb begin
    state_next = state;
    load = 1'b0;
    step = (state == ST_ROUND);
    push = 1'b0;
    push_data = 32'h0;
    unique case (state)
      ST_IDLE: if (in_msg) begin
        push = 1'b1;
        push_data = (last_word && cnt != 3'd4) ? lw : data_word;
        if (wpos == 4'd15) begin state_next = ST_ROUND; load = 1'b1; end
        else if (last_word) state_next = ST_PAD;
      end
      ST_PAD: begin
        push = (ph != 2'd3);
        push_data = need80 ? 32'h80000000 :
                    (ph == 2'd1) ? bit_count[63:32] :
                    (ph == 2'd2) ? bit_count[31:0] : 32'h0;
        if (push && wpos == 4'd15) begin state_next = ST_ROUND; load = 1'b1; end
      end
      ST_ROUND: if (rnd == 6'd63) state_next = ST_ADD;
      ST_ADD: state_next = !last_blk ? ST_IDLE : (pad_phase == 2'd3) ? ST_OUT : ST_PAD;
      ST_OUT: if (!out_stall && last_digest_word) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // block load happens on the same edge as the final push, so bypass it
  always_comb begin
    blk_in = blk;
    if (push) blk_in[wpos] = push_data;
  end

  always_ff @(posedge clk) begin
    if (push) blk[wpos] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode <= 1'b0;
      bit_count <= '0;
      wpos <= '0;
      rnd <= '0;
      oidx <= '0;
      pad_phase <= '0;
      last_blk <= 1'b0;
      for (int i = 0; i < 8; i++) hv[i] <= init_hash(1'b0, 3'(i));
    end else begin
      state <= state_next;
      if (push) wpos <= wpos + 4'd1;
      if (state == ST_ROUND) rnd <= rnd + 6'd1;
      if (state == ST_ADD) for (int i = 0; i < 8; i++) hv[i] <= hv[i] + v[i];
      if (state == ST_IDLE && in_msg) begin
        last_blk <= last_word;
        pad_phase <= 2'd0;
        bit_count <= bit_count + (last_word ? {58'd0, cnt, 3'd0} : 64'd32);
      end
      if (state == ST_PAD && push) begin
        if (ph == 2'd0 && wpos == 4'd13) pad_phase <= 2'd1;
        else if (ph == 2'd1) pad_phase <= 2'd2;
        else if (ph == 2'd2) pad_phase <= 2'd3;
      end
      if (state == ST_OUT && !out_stall) begin
        if (last_digest_word) begin
          oidx <= '0;
          bit_count <= '0;
          wpos <= '0;
          for (int i = 0; i < 8; i++) hv[i] <= init_hash(mode, 3'(i));
        end else begin
          oidx <= oidx + 3'd1;
        end
      end
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
        bit_count <= '0;
        wpos <= '0;
        for (int i = 0; i < 8; i++) hv[i] <= init_hash(cfg_data, 3'(i));
      end
    end
  end

  // a full last word needs its own 0x80 word
  always_ff @(posedge clk) begin
    if (rst) need80 <= 1'b0;
    else if (state == ST_IDLE && in_msg) need80 <= last_word && cnt == 3'd4;
    else if (state == ST_PAD && push) need80 <= 1'b0;
  end

  `ASSERT_IMPLIES(a_stall_busy, clk, rst, state == ST_ROUND, in_stall && !out_valid)
  `ASSERT_NEXT(a_round_end, clk, rst, state == ST_ROUND && rnd == 6'd63, state == ST_ADD)
  `ASSERT_IMPLIES(a_out_idx, clk, rst, out_valid, !(mode && oidx == 3'd7))
endmodule

// ----- tb/tb_sha256_sha224_hash_core.sv -----
module tb_sha256_sha224_hash_core;
  import shah_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  class digest_scoreboard;
    logic        mode;
    logic [31:0] hv [8];
    logic [31:0] blk [16];
    logic [63:0] nbits;
    int unsigned pos;
    digest_beat_t pending[$];
    int errors;
    int matched;

    function new();
      errors = 0;
      matched = 0;
      set_mode(1'b0);
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void reload();
      logic [31:0] h256 [8];
      logic [31:0] h224 [8];
      h256 = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      h224 = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
               32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
      for (int i = 0; i < 8; i++) hv[i] = mode ? h224[i] : h256[i];
      nbits = '0;
      pos = 0;
    endfunction

    function void set_mode(logic m);
      mode = m;
      reload();
    endfunction

    function void compress_block();
      logic [31:0] kk [64];
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2, ch, mj;
      kk = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      for (int j = 0; j < 16; j++) w[j] = blk[j];
      for (int j = 16; j < 64; j++) begin
        s0 = ror(w[j-15], 7) ^ ror(w[j-15], 18) ^ (w[j-15] >> 3);
        s1 = ror(w[j-2], 17) ^ ror(w[j-2], 19) ^ (w[j-2] >> 10);
        w[j] = w[j-16] + s0 + w[j-7] + s1;
      end
      for (int j = 0; j < 8; j++) v[j] = hv[j];
      for (int j = 0; j < 64; j++) begin
        ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) + ch + kk[j] + w[j];
        mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) + mj;
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) hv[j] += v[j];
    endfunction

    function void push(logic [31:0] x);
      blk[pos] = x;
      pos++;
      if (pos == 16) begin
        compress_block();
        pos = 0;
      end
    endfunction

    // note an accepted input beat
    function void note_input(logic [31:0] d, logic [2:0] cnt, logic lst);
      int unsigned c;
      logic [31:0] keep, x;
      digest_beat_t b;
      if (!lst) begin
        nbits += 32;
        push(d);
        return;
      end
      c = (cnt > 4) ? 4 : cnt;
      nbits += c * 8;
      if (c == 4) begin
        push(d);
        push(32'h80000000);
      end else begin
        keep = (c == 0) ? 32'h0 : (32'hffffffff << (8 * (4 - c)));
        x = (d & keep) | (32'h80 << (8 * (3 - c)));
        push(x);
      end
      if (pos > 14) while (pos != 0) push('0);
      while (pos < 14) push('0);
      push(nbits[63:32]);
      push(nbits[31:0]);
      for (int k = 0; k < (mode ? 7 : 8); k++) begin
        b.word = hv[k];
        b.idx = 3'(k);
        b.last = (k == (mode ? 6 : 7));
        pending.push_back(b);
      end
      reload();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_digest(logic [31:0] d, logic [2:0] i, logic l);
      digest_beat_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected digest beat %h idx %0d", d, i));
        return;
      end
      e = pending.pop_front();
      if (d !== e.word || i !== e.idx || l !== e.last)
        report_mismatch($sformatf("got %h/%0d/%b want %h/%0d/%b",
                                  d, i, l, e.word, e.idx, e.last));
      else
        matched++;
    endtask
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready, cfg_data;
  logic in_valid, in_stall;
  logic [31:0] data_word;
  logic [2:0] byte_count;
  logic last_word;
  logic out_valid, out_stall;
  logic [31:0] digest_word;
  logic [2:0] word_index;
  logic last_digest_word;

  digest_scoreboard sb;
  int idle_pct, stall_pct;
  int cycles;
  int n_msgs;
  int n_mode_writes;

  sha256_sha224_hash_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_word(data_word), .byte_count(byte_count), .last_word(last_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .word_index(word_index),
    .last_digest_word(last_digest_word)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver side: stall at random and check digest beats
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_digest(digest_word, word_index, last_digest_word);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_beat(logic [31:0] d, logic [2:0] c, logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_word <= d;
    byte_count <= c;
    last_word <= l;
    do @(posedge clk); while (in_stall);
    sb.note_input(d, c, l);
    if (l) n_msgs++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_mode(m);
    n_mode_writes++;
  endtask

  // message of nw full words then a last word of cnt bytes
  task automatic send_msg(int nw, logic [2:0] cnt);
    for (int i = 0; i < nw; i++)
      send_beat($urandom, 3'($urandom_range(7)), 1'b0);
    send_beat($urandom, cnt, 1'b1);
  endtask

  task automatic random_msgs(int beats);
    int sent;
    int nw;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(9) == 0) nw = $urandom_range(40);
      else nw = $urandom_range(17);
      send_msg(nw, 3'($urandom_range(7)));
      sent += nw + 1;
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    n_msgs = 0;
    n_mode_writes = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    data_word = '0;
    byte_count = '0;
    last_word = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, extreme words, every byte count, padding overflow
    send_beat(32'h0, 3'd0, 1'b1);
    send_beat(32'hffffffff, 3'd4, 1'b1);
    send_beat(32'h61626380, 3'd3, 1'b1);
    send_beat(32'hffffffff, 3'd1, 1'b1);
    send_beat(32'hffffffff, 3'd2, 1'b1);
    send_beat(32'hffffffff, 3'd7, 1'b1);
    send_msg(13, 3'd3);
    send_msg(13, 3'd4);
    send_msg(14, 3'd0);
    write_mode(1'b1);
    send_beat(32'h61626300, 3'd3, 1'b1);
    send_beat(32'h0, 3'd5, 1'b1);
    // mode write in the middle of a message aborts it
    send_beat(32'h12345678, 3'd4, 1'b0);
    send_beat(32'hdeadbeef, 3'd4, 1'b0);
    write_mode(1'b0);
    send_beat(32'h0, 3'd6, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      write_mode(ph[0]);
      random_msgs(20);
      // sender holds off until all digests are back
      drain();
      random_msgs(14);
    end
    idle_pct = 0;
    stall_pct = 0;
    drain();

    $display("ran %0d messages over %0d mode writes, %0d digest words matched",
             n_msgs, n_mode_writes, sb.matched);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d beats outstanding", sb.errors, sb.pending.size());
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+sv
sv/shah_pkg.sv
sv/shah_round.sv
sv/sha256_sha224_hash_core.sv
tb/tb_sha256_sha224_hash_core.sv
